/* rtl/variable_partition_allocator_defines.svh */
// Assertion macros for the variable partition allocator.
// Included by files that carry concurrent assertions; no other dependency.
`ifndef VARIABLE_PARTITION_ALLOCATOR_DEFINES_SVH
`define VARIABLE_PARTITION_ALLOCATOR_DEFINES_SVH

// plain property, checked every edge outside reset
`define VPA_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// antecedent this edge, consequent on the next one
`define VPA_ASSERT_NX(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/vpa_pkg.sv */
// Shared constants and codes for the variable partition allocator.
// No dependencies.
package vpa_pkg;

  localparam int MAX_BLOCKS_DEF = 16;
  localparam int ADDR_BITS_DEF  = 16;
  localparam int FIELD_W        = 16;
  localparam int STATUS_W       = 3;
  localparam int CFG_IDX_W      = 1;

  localparam logic [FIELD_W-1:0] MEM_SIZE_RST = 16'd1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] POL_BEST  = 2'd0;
  localparam logic [1:0] POL_WORST = 2'd1;
  localparam logic [1:0] POL_FIRST = 2'd2;
  localparam logic [1:0] POL_NONE  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOID  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOPOL = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MEMSZ  = 1'b1;

endpackage

/* rtl/vpa_ifs.sv */
// Request and response channel interfaces of the variable partition allocator.
// Depends on vpa_pkg.
interface vpa_req_if;
  import vpa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [FIELD_W-1:0]   request_size;
  logic [FIELD_W-1:0]   target_id;
  modport source(output valid, opcode, request_size, target_id, input ready);
  modport sink(input valid, opcode, request_size, target_id, output ready);
endinterface

interface vpa_rsp_if;
  import vpa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [FIELD_W-1:0]   block_id;
  logic [FIELD_W-1:0]   block_start;
  logic [FIELD_W-1:0]   block_size;
  modport source(output valid, status, block_id, block_start, block_size, input ready);
  modport sink(input valid, status, block_id, block_start, block_size, output ready);
endinterface

/* rtl/variable_partition_allocator.sv */
// Channel   Dir  Handshake       Payload
// req       in   valid/ready     opcode, request_size, target_id
// rsp       out  valid/ready     status, block_id, block_start, block_size
// cfg       in   cfg_we          cfg_index, cfg_data
//
// Free list and used list each live in a 1R1W memory with registered read.
// An item scans the used list (free only) then the free list, one entry a
// cycle, then shifts one or both lists one entry a cycle.
// Reset is synchronous; the INIT state entered on reset writes the initial free block.
// A held result does not stop the next item from being accepted; that item
// then waits in its last cycle until the held result is taken.
// Depends on vpa_pkg, vpa_ifs and variable_partition_allocator_defines.svh.
`include "variable_partition_allocator_defines.svh"

module variable_partition_allocator #(
  parameter int MAX_BLOCKS = vpa_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_BITS  = vpa_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  vpa_req_if.sink                        req,
  vpa_rsp_if.source                      rsp,
  input  logic                           cfg_we,
  input  logic [vpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vpa_pkg::FIELD_W-1:0]    cfg_data
);
  import vpa_pkg::*;

  localparam int AW = ADDR_BITS;
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int FW = 2 * AW;
  localparam int UW = FIELD_W + 2 * AW;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_USCAN  = 4'd2;
  localparam logic [3:0] S_FSCAN  = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_FREM   = 4'd5;
  localparam logic [3:0] S_FPUSH  = 4'd6;
  localparam logic [3:0] S_UREM   = 4'd7;
  localparam logic [3:0] S_UPUSH  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  function automatic logic [AW-1:0] to_a(input logic [FIELD_W-1:0] v);
    logic [47:0] w;
    w = 48'(v);
    return w[AW-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] to_w(input logic [AW-1:0] v);
    logic [47:0] w;
    w = 48'(v);
    return w[FIELD_W-1:0];
  endfunction

  // memories
  logic [FW-1:0] fmem [MAX_BLOCKS];
  logic [UW-1:0] umem [MAX_BLOCKS];
  logic          f_we, u_we;
  logic [IW-1:0] f_wa, f_ra, u_wa, u_ra;
  logic [FW-1:0] f_wd, f_rd;
  logic [UW-1:0] u_wd, u_rd;

  always_ff @(posedge clk) begin
    if (f_we) fmem[f_wa] <= f_wd;
    f_rd <= fmem[f_ra];
  end

  always_ff @(posedge clk) begin
    if (u_we) umem[u_wa] <= u_wd;
    u_rd <= umem[u_ra];
  end

  // control and payload registers
  logic [3:0]          state;
  logic [CW-1:0]       free_cnt, used_cnt;
  logic [1:0]          fit_policy;
  logic [FIELD_W-1:0]  mem_total;
  logic [FIELD_W-1:0]  id_counter;
  logic [CW-1:0]       rd_idx, sw_ptr;
  logic                chk, pend;
  logic [IW-1:0]       chk_idx, pend_idx;
  logic                op;
  logic [AW-1:0]       req_a;
  logic [FIELD_W-1:0]  tid;
  logic                pick_ok, front_ok, back_ok, u_ok;
  logic [IW-1:0]       pick_idx, front_idx, back_idx, u_idx;
  logic [AW-1:0]       pick_start, pick_len, front_start, front_len, back_len;
  logic [AW-1:0]       u_start, u_len;
  logic [STATUS_W-1:0] p_status, res_status;
  logic [FIELD_W-1:0]  p_bid, p_start, p_size, res_bid, res_start, res_size;
  logic                res_valid;

  logic [AW-1:0]      fr_start, fr_len, ur_start, ur_len;
  logic [FIELD_W-1:0] ur_id;
  logic               scan_issue, rem_issue, push_issue, better, back_use, cfg_mem_wr;

  assign fr_start = f_rd[FW-1:AW];
  assign fr_len   = f_rd[AW-1:0];
  assign ur_id    = u_rd[UW-1:FW];
  assign ur_start = u_rd[FW-1:AW];
  assign ur_len   = u_rd[AW-1:0];

  assign scan_issue = (state == S_USCAN) ? (rd_idx < used_cnt) : (rd_idx < free_cnt);
  assign rem_issue  = (state == S_UREM) ? (sw_ptr < used_cnt) : (sw_ptr < free_cnt);
  assign push_issue = (sw_ptr != '0);
  assign back_use   = back_ok && !(front_ok && back_idx == front_idx);
  assign cfg_mem_wr = cfg_we && cfg_index == REG_MEMSZ && used_cnt == '0;

  always_comb begin
    unique case (fit_policy)
      POL_BEST:  better = fr_len < pick_len;
      POL_WORST: better = fr_len > pick_len;
      default:   better = 1'b0;
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = res_valid;
  assign rsp.status      = res_status;
  assign rsp.block_id    = res_bid;
  assign rsp.block_start = res_start;
  assign rsp.block_size  = res_size;

  // memory port steering
  always_comb begin
    f_we = 1'b0;
    f_wa = '0;
    f_wd = '0;
    f_ra = '0;
    u_we = 1'b0;
    u_wa = '0;
    u_wd = '0;
    u_ra = '0;
    if (cfg_mem_wr) begin
      f_we = 1'b1;
      f_wd = {{AW{1'b0}}, to_a(cfg_data)};
    end else begin
      unique case (state)
        S_INIT: begin
          f_we = 1'b1;
          f_wd = {{AW{1'b0}}, to_a(mem_total)};
        end
        S_USCAN: u_ra = rd_idx[IW-1:0];
        S_FSCAN: f_ra = rd_idx[IW-1:0];
        S_DECIDE: begin
          if (op == OP_ALLOC) begin
            if (pick_ok && pick_len != req_a) begin
              f_we = 1'b1;
              f_wa = pick_idx;
              f_wd = {AW'(pick_start + req_a), AW'(pick_len - req_a)};
            end
          end else if (front_ok) begin
            f_we = 1'b1;
            f_wa = front_idx;
            f_wd = {front_start,
                    AW'(front_len + u_len + (back_use ? back_len : AW'(0)))};
          end else if (back_use) begin
            f_we = 1'b1;
            f_wa = back_idx;
            f_wd = {u_start, AW'(back_len + u_len)};
          end
        end
        S_FREM: begin
          f_ra = sw_ptr[IW-1:0];
          f_we = pend;
          f_wa = pend_idx;
          f_wd = f_rd;
        end
        S_FPUSH: begin
          f_ra = IW'(sw_ptr - CW'(1));
          if (pend) begin
            f_we = 1'b1;
            f_wa = pend_idx;
            f_wd = f_rd;
          end else if (!push_issue) begin
            f_we = 1'b1;
            f_wd = {u_start, u_len};
          end
        end
        S_UREM: begin
          u_ra = sw_ptr[IW-1:0];
          u_we = pend;
          u_wa = pend_idx;
          u_wd = u_rd;
        end
        S_UPUSH: begin
          u_ra = IW'(sw_ptr - CW'(1));
          if (pend) begin
            u_we = 1'b1;
            u_wa = pend_idx;
            u_wd = u_rd;
          end else if (!push_issue) begin
            u_we = 1'b1;
            u_wd = {id_counter, pick_start, req_a};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      free_cnt   <= CW'(1);
      used_cnt   <= '0;
      fit_policy <= POL_NONE;
      mem_total  <= MEM_SIZE_RST;
      id_counter <= '0;
      chk        <= 1'b0;
      pend       <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_POLICY) fit_policy <= cfg_data[1:0];
      if (cfg_mem_wr) begin
        mem_total <= cfg_data;
        free_cnt  <= CW'(1);
      end
      if (res_valid && rsp.ready && state != S_DONE) res_valid <= 1'b0;

      unique case (state)
        S_INIT: state <= S_IDLE;

        S_IDLE: begin
          if (req.valid) begin
            op       <= req.opcode;
            req_a    <= to_a(req.request_size);
            tid      <= req.target_id;
            p_start  <= '0;
            p_size   <= '0;
            rd_idx   <= '0;
            chk      <= 1'b0;
            pick_ok  <= 1'b0;
            front_ok <= 1'b0;
            back_ok  <= 1'b0;
            u_ok     <= 1'b0;
            if (req.opcode == OP_FREE) begin
              p_status <= ST_OK;
              p_bid    <= '0;
              state    <= S_USCAN;
            end else if (fit_policy == POL_NONE) begin
              p_status <= ST_NOPOL;
              p_bid    <= '0;
              state    <= S_DONE;
            end else begin
              // the id is spent even when the allocate fails
              id_counter <= id_counter + 16'd1;
              p_bid      <= id_counter + 16'd1;
              if (used_cnt == CNT_MAX) begin
                p_status <= ST_FULL;
                state    <= S_DONE;
              end else begin
                p_status <= ST_OK;
                state    <= S_FSCAN;
              end
            end
          end
        end

        S_USCAN: begin
          chk <= scan_issue;
          if (scan_issue) begin
            rd_idx  <= rd_idx + CW'(1);
            chk_idx <= rd_idx[IW-1:0];
          end
          if (chk && !u_ok && ur_id == tid) begin
            u_ok    <= 1'b1;
            u_idx   <= chk_idx;
            u_start <= ur_start;
            u_len   <= ur_len;
          end
          if (!scan_issue && !chk) begin
            if (!u_ok) begin
              p_status <= ST_NOID;
              p_bid    <= tid;
              state    <= S_DONE;
            end else begin
              rd_idx <= '0;
              state  <= S_FSCAN;
            end
          end
        end

        S_FSCAN: begin
          chk <= scan_issue;
          if (scan_issue) begin
            rd_idx  <= rd_idx + CW'(1);
            chk_idx <= rd_idx[IW-1:0];
          end
          if (chk) begin
            if (fr_len >= req_a && (!pick_ok || better)) begin
              pick_ok    <= 1'b1;
              pick_idx   <= chk_idx;
              pick_start <= fr_start;
              pick_len   <= fr_len;
            end
            if (!front_ok && AW'(fr_start + fr_len) == u_start) begin
              front_ok    <= 1'b1;
              front_idx   <= chk_idx;
              front_start <= fr_start;
              front_len   <= fr_len;
            end
            if (!back_ok && fr_start == AW'(u_start + u_len)) begin
              back_ok  <= 1'b1;
              back_idx <= chk_idx;
              back_len <= fr_len;
            end
          end
          if (!scan_issue && !chk) state <= S_DECIDE;
        end

        S_DECIDE: begin
          pend <= 1'b0;
          if (op == OP_ALLOC) begin
            if (!pick_ok) begin
              p_status <= ST_NOFIT;
              state    <= S_DONE;
            end else begin
              p_start <= to_w(pick_start);
              p_size  <= to_w(req_a);
              if (pick_len != req_a) begin
                sw_ptr <= used_cnt;
                state  <= S_UPUSH;
              end else begin
                sw_ptr <= CW'(pick_idx) + CW'(1);
                state  <= S_FREM;
              end
            end
          end else if (!front_ok && !back_use && free_cnt == CNT_MAX) begin
            p_status <= ST_FULL;
            p_bid    <= '0;
            p_start  <= '0;
            p_size   <= '0;
            state    <= S_DONE;
          end else begin
            p_bid   <= tid;
            p_start <= to_w(u_start);
            p_size  <= to_w(u_len);
            if (front_ok && back_use) begin
              sw_ptr <= CW'(back_idx) + CW'(1);
              state  <= S_FREM;
            end else if (front_ok || back_use) begin
              sw_ptr <= CW'(u_idx) + CW'(1);
              state  <= S_UREM;
            end else begin
              sw_ptr <= free_cnt;
              state  <= S_FPUSH;
            end
          end
        end

        S_FREM, S_UREM: begin
          pend <= rem_issue;
          if (rem_issue) begin
            sw_ptr   <= sw_ptr + CW'(1);
            pend_idx <= IW'(sw_ptr - CW'(1));
          end
          if (!rem_issue && !pend) begin
            if (state == S_FREM) begin
              free_cnt <= free_cnt - CW'(1);
              if (op == OP_ALLOC) begin
                sw_ptr <= used_cnt;
                state  <= S_UPUSH;
              end else begin
                sw_ptr <= CW'(u_idx) + CW'(1);
                state  <= S_UREM;
              end
            end else begin
              used_cnt <= used_cnt - CW'(1);
              state    <= S_DONE;
            end
          end
        end

        S_FPUSH, S_UPUSH: begin
          pend <= push_issue;
          if (push_issue) begin
            sw_ptr   <= sw_ptr - CW'(1);
            pend_idx <= sw_ptr[IW-1:0];
          end
          if (!push_issue && !pend) begin
            if (state == S_FPUSH) begin
              free_cnt <= free_cnt + CW'(1);
              sw_ptr   <= CW'(u_idx) + CW'(1);
              state    <= S_UREM;
            end else begin
              used_cnt <= used_cnt + CW'(1);
              state    <= S_DONE;
            end
          end
        end

        S_DONE: begin
          if (!res_valid || rsp.ready) begin
            res_valid  <= 1'b1;
            res_status <= p_status;
            res_bid    <= p_bid;
            res_start  <= p_start;
            res_size   <= p_size;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `VPA_ASSERT(a_fpush_room, clk, rst, (state == S_FPUSH) |-> (free_cnt < CNT_MAX), "free push on full list")
  `VPA_ASSERT(a_upush_room, clk, rst, (state == S_UPUSH) |-> (used_cnt < CNT_MAX), "used push on full list")
  `VPA_ASSERT_NX(a_init_one, clk, rst, state == S_INIT, free_cnt == CW'(1), "init left bad free count")
  `VPA_ASSERT_NX(a_id_step, clk, rst, req.valid && req.ready && req.opcode == OP_ALLOC && fit_policy != POL_NONE, id_counter == 16'($past(id_counter) + 16'd1), "id not advanced")

endmodule

/* tb/variable_partition_allocator_test.sv */
// Self-checking test of the variable partition allocator: directed table, then random phases.
// Depends on vpa_pkg, vpa_ifs and the variable_partition_allocator RTL.
module variable_partition_allocator_test;
  import vpa_pkg::*;

  localparam int NB = 16;
  localparam int CYCLE_LIMIT = 800000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [15:0]         block_id;
    logic [15:0]         block_start;
    logic [15:0]         block_size;
  } outcome_t;

  typedef enum logic {K_ITEM, K_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic      op;
    logic [15:0] a;   // request_size, or register index
    logic [15:0] b;   // target_id, or register data
    bit        chk;
    outcome_t  res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0] cfg_data = '0;
  logic rx_ready = 1'b0;

  vpa_req_if req_ch();
  vpa_rsp_if rsp_ch();
  assign rsp_ch.ready = rx_ready;

  variable_partition_allocator i_dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // mirror of the allocator state
  logic [15:0] fr_start [NB];
  logic [15:0] fr_len   [NB];
  bit          fr_vld   [NB];
  logic [15:0] us_id    [NB];
  logic [15:0] us_start [NB];
  logic [15:0] us_len   [NB];
  bit          us_vld   [NB];
  logic [15:0] id_ctr;
  logic [1:0]  cur_pol;
  logic [15:0] mem_sz;

  outcome_t outcome_q[$];
  int  mismatches = 0;
  int  cycles = 0;
  int  burst_left = 0;
  bit  long_hold_go = 0;

  function automatic int live_count(input bit v [NB]);
    int n;
    n = 0;
    for (int i = 0; i < NB; i++) if (v[i]) n++;
    return n;
  endfunction

  function automatic void clear_free_list();
    for (int i = 0; i < NB; i++) begin
      fr_start[i] = '0; fr_len[i] = '0; fr_vld[i] = 0;
    end
    fr_len[0] = mem_sz;
    fr_vld[0] = 1;
  endfunction

  function automatic void free_drop(input int k);
    for (int j = k; j < NB - 1; j++) begin
      fr_start[j] = fr_start[j+1]; fr_len[j] = fr_len[j+1]; fr_vld[j] = fr_vld[j+1];
    end
    fr_start[NB-1] = '0; fr_len[NB-1] = '0; fr_vld[NB-1] = 0;
  endfunction

  function automatic void used_drop(input int k);
    for (int j = k; j < NB - 1; j++) begin
      us_id[j] = us_id[j+1]; us_start[j] = us_start[j+1];
      us_len[j] = us_len[j+1]; us_vld[j] = us_vld[j+1];
    end
    us_vld[NB-1] = 0;
  endfunction

  function automatic void reset_allocator();
    cur_pol = POL_NONE;
    mem_sz = MEM_SIZE_RST;
    id_ctr = '0;
    clear_free_list();
    for (int i = 0; i < NB; i++) us_vld[i] = 0;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [15:0] val);
    if (idx == REG_POLICY) cur_pol = val[1:0];
    else if (live_count(us_vld) == 0) begin
      mem_sz = val;
      clear_free_list();
    end
  endfunction

  function automatic outcome_t compute_outcome(input logic op, input logic [15:0] sz,
                                               input logic [15:0] tid);
    outcome_t o;
    int pick, u, front, back;
    logic [15:0] s, l, e;
    o = '0;
    if (op == OP_ALLOC) begin
      if (cur_pol == POL_NONE) o.status = ST_NOPOL;
      else begin
        id_ctr = id_ctr + 16'd1;
        o.block_id = id_ctr;
        if (live_count(us_vld) >= NB) o.status = ST_FULL;
        else begin
          pick = -1;
          for (int i = 0; i < NB; i++) begin
            if (!fr_vld[i] || fr_len[i] < sz) continue;
            if (cur_pol == POL_FIRST) begin
              pick = i;
              break;
            end
            if (pick < 0 || (cur_pol == POL_BEST && fr_len[i] < fr_len[pick]) ||
                (cur_pol == POL_WORST && fr_len[i] > fr_len[pick])) pick = i;
          end
          if (pick < 0) o.status = ST_NOFIT;
          else begin
            o.block_start = fr_start[pick];
            o.block_size = sz;
            if (fr_len[pick] != sz) begin
              fr_start[pick] = fr_start[pick] + sz;
              fr_len[pick] = fr_len[pick] - sz;
            end else free_drop(pick);
            for (int j = NB - 1; j > 0; j--) begin
              us_id[j] = us_id[j-1]; us_start[j] = us_start[j-1];
              us_len[j] = us_len[j-1]; us_vld[j] = us_vld[j-1];
            end
            us_id[0] = o.block_id; us_start[0] = o.block_start;
            us_len[0] = sz; us_vld[0] = 1;
          end
        end
      end
    end else begin
      u = -1;
      for (int i = 0; i < NB; i++)
        if (us_vld[i] && us_id[i] == tid) begin
          u = i;
          break;
        end
      if (u < 0) begin
        o.status = ST_NOID;
        o.block_id = tid;
      end else begin
        s = us_start[u]; l = us_len[u]; e = s + l;
        front = -1; back = -1;
        for (int i = 0; i < NB; i++)
          if (fr_vld[i] && 16'(fr_start[i] + fr_len[i]) == s) begin
            front = i;
            break;
          end
        for (int i = 0; i < NB; i++)
          if (fr_vld[i] && fr_start[i] == e) begin
            back = i;
            break;
          end
        if (back == front) back = -1;
        if (front >= 0) begin
          fr_len[front] = fr_len[front] + l;
          if (back >= 0) begin
            fr_len[front] = fr_len[front] + fr_len[back];
            free_drop(back);
          end
        end else if (back >= 0) begin
          fr_start[back] = s;
          fr_len[back] = fr_len[back] + l;
        end else if (live_count(fr_vld) >= NB) begin
          o.status = ST_FULL;
          return o;
        end else begin
          for (int j = NB - 1; j > 0; j--) begin
            fr_start[j] = fr_start[j-1]; fr_len[j] = fr_len[j-1]; fr_vld[j] = fr_vld[j-1];
          end
          fr_start[0] = s; fr_len[0] = l; fr_vld[0] = 1;
        end
        used_drop(u);
        o.block_id = tid; o.block_start = s; o.block_size = l;
      end
    end
    return o;
  endfunction

  task automatic send_item(input logic op, input logic [15:0] sz, input logic [15:0] tid,
                           input bit chk, input outcome_t typed);
    outcome_t o;
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.request_size <= sz;
    req_ch.target_id <= tid;
    do @(posedge clk); while (!req_ch.ready);
    burst_left--;
    o = compute_outcome(op, sz, tid);
    outcome_q.push_back(chk ? typed : o);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    req_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_register(idx, val);
  endtask

  function automatic row_t mk(input row_kind_t k, input logic op, input logic [15:0] a,
                              input logic [15:0] b, input bit chk,
                              input logic [STATUS_W-1:0] st, input logic [15:0] id,
                              input logic [15:0] start, input logic [15:0] size);
    row_t r;
    r.kind = k; r.op = op; r.a = a; r.b = b; r.chk = chk;
    r.res = '{st, id, start, size};
    return r;
  endfunction

  // receiver: rotating stall pattern plus one long hold-off
  int rx_cyc = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      rx_ready <= 1'b0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (long_hold_go && !hold_done) begin
        hold_left <= 400;
        hold_done <= 1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
      case ((rx_cyc / 200) % 3)
        0: rx_ready <= (hold_left == 0);
        1: rx_ready <= (hold_left == 0) && ($urandom_range(0, 2) != 0);
        default: rx_ready <= (hold_left == 0) && (rx_cyc % 4 == 0);
      endcase
      if (rsp_ch.valid && rx_ready) begin
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item: %0d %0d %0d %0d",
            rsp_ch.status, rsp_ch.block_id, rsp_ch.block_start, rsp_ch.block_size);
        end else begin
          want = outcome_q.pop_front();
          if (want != {rsp_ch.status, rsp_ch.block_id, rsp_ch.block_start,
                       rsp_ch.block_size}) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st %0d id %0d start %0d size %0d, got %0d %0d %0d %0d",
                want.status, want.block_id, want.block_start, want.block_size,
                rsp_ch.status, rsp_ch.block_id, rsp_ch.block_start, rsp_ch.block_size);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("variable_partition_allocator_test failed");
      $finish;
    end
  end

  initial begin
    row_t dir_tab[$];
    logic [1:0]  ph_pol [6];
    logic [15:0] ph_mem [6];
    logic [15:0] sz, tid;
    logic op;
    int tries, k;
    outcome_t none;
    none = '0;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OP_ALLOC;
    req_ch.request_size <= '0;
    req_ch.target_id <= '0;
    reset_allocator();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    repeat (5) @(posedge clk);

    dir_tab = '{
      mk(K_ITEM, OP_ALLOC, 16'd5, 16'd0, 1'b1, ST_NOPOL, 16'd0, 16'd0, 16'd0),
      mk(K_ITEM, OP_FREE, 16'd0, 16'd0, 1'b1, ST_NOID, 16'd0, 16'd0, 16'd0),
      mk(K_ITEM, OP_FREE, 16'hffff, 16'hffff, 1'b1, ST_NOID, 16'hffff, 16'd0, 16'd0),
      mk(K_CFG, OP_ALLOC, 16'(REG_POLICY), 16'(POL_BEST), 1'b0, ST_OK, 16'd0, 16'd0, 16'd0),
      mk(K_ITEM, OP_ALLOC, 16'd100, 16'd0, 1'b1, ST_OK, 16'd1, 16'd0, 16'd100),
      mk(K_ITEM, OP_ALLOC, 16'd0, 16'd0, 1'b1, ST_OK, 16'd2, 16'd100, 16'd0),
      mk(K_ITEM, OP_ALLOC, 16'hffff, 16'd0, 1'b1, ST_NOFIT, 16'd3, 16'd0, 16'd0),
      mk(K_ITEM, OP_ALLOC, 16'd924, 16'd0, 1'b1, ST_OK, 16'd4, 16'd100, 16'd924),
      mk(K_ITEM, OP_FREE, 16'd0, 16'd2, 1'b1, ST_OK, 16'd2, 16'd100, 16'd0),
      mk(K_ITEM, OP_FREE, 16'd0, 16'd1, 1'b1, ST_OK, 16'd1, 16'd0, 16'd100),
      mk(K_ITEM, OP_FREE, 16'd0, 16'd4, 1'b1, ST_OK, 16'd4, 16'd100, 16'd924),
      mk(K_ITEM, OP_FREE, 16'd0, 16'd4, 1'b1, ST_NOID, 16'd4, 16'd0, 16'd0),
      mk(K_CFG, OP_ALLOC, 16'(REG_MEMSZ), 16'd1, 1'b0, ST_OK, 16'd0, 16'd0, 16'd0),
      mk(K_ITEM, OP_ALLOC, 16'd1, 16'd0, 1'b1, ST_OK, 16'd5, 16'd0, 16'd1),
      mk(K_ITEM, OP_ALLOC, 16'd1, 16'd0, 1'b1, ST_NOFIT, 16'd6, 16'd0, 16'd0),
      mk(K_CFG, OP_ALLOC, 16'(REG_MEMSZ), 16'd500, 1'b0, ST_OK, 16'd0, 16'd0, 16'd0),
      mk(K_ITEM, OP_FREE, 16'd0, 16'd5, 1'b1, ST_OK, 16'd5, 16'd0, 16'd1),
      mk(K_CFG, OP_ALLOC, 16'(REG_MEMSZ), 16'hffff, 1'b0, ST_OK, 16'd0, 16'd0, 16'd0),
      mk(K_CFG, OP_ALLOC, 16'(REG_POLICY), 16'(POL_WORST), 1'b0, ST_OK, 16'd0, 16'd0, 16'd0),
      mk(K_ITEM, OP_ALLOC, 16'hffff, 16'd0, 1'b1, ST_OK, 16'd7, 16'd0, 16'hffff),
      mk(K_ITEM, OP_ALLOC, 16'd0, 16'd0, 1'b1, ST_NOFIT, 16'd8, 16'd0, 16'd0),
      mk(K_ITEM, OP_FREE, 16'd0, 16'd7, 1'b1, ST_OK, 16'd7, 16'd0, 16'hffff),
      mk(K_CFG, OP_ALLOC, 16'(REG_POLICY), 16'(POL_FIRST), 1'b0, ST_OK, 16'd0, 16'd0, 16'd0),
      mk(K_ITEM, OP_ALLOC, 16'h5555, 16'haaaa, 1'b0, ST_OK, 16'd0, 16'd0, 16'd0),
      mk(K_ITEM, OP_ALLOC, 16'haaaa, 16'h5555, 1'b0, ST_OK, 16'd0, 16'd0, 16'd0),
      mk(K_ITEM, OP_FREE, 16'h5555, 16'd9, 1'b0, ST_OK, 16'd0, 16'd0, 16'd0)
    };
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == K_CFG) write_register(dir_tab[i].a[CFG_IDX_W-1:0], dir_tab[i].b);
      else send_item(dir_tab[i].op, dir_tab[i].a, dir_tab[i].b, dir_tab[i].chk,
                     dir_tab[i].res);
    end

    ph_pol = '{POL_BEST, POL_WORST, POL_FIRST, POL_BEST, POL_NONE, POL_WORST};
    ph_mem = '{16'd1024, 16'hffff, 16'd300, 16'd40000, 16'd1024, 16'd7};
    for (int ph = 0; ph < 6; ph++) begin
      // empty the used list so the size write takes; a failing free is simply retried
      tries = 0;
      while (live_count(us_vld) != 0 && tries < 64) begin
        k = $urandom_range(0, live_count(us_vld) - 1);
        send_item(OP_FREE, 16'($urandom), us_id[k], 1'b0, none);
        tries++;
      end
      write_register(REG_MEMSZ, ph_mem[ph]);
      write_register(REG_POLICY, {14'd0, ph_pol[ph]});
      if (ph == 1) long_hold_go = 1;
      for (int n = 0; n < ((ph == 4) ? 60 : 240); n++) begin
        op = ($urandom_range(0, 99) < 55) ? OP_ALLOC : OP_FREE;
        sz = 16'($urandom);
        tid = 16'($urandom);
        if (op == OP_ALLOC) begin
          case ($urandom_range(0, 19))
            0: sz = 16'd0;
            1, 2: sz = 16'($urandom);
            default: sz = 16'($urandom_range(0, int'(mem_sz) / 6 + 1));
          endcase
        end else if (live_count(us_vld) != 0 && $urandom_range(0, 9) < 8) begin
          tid = us_id[$urandom_range(0, live_count(us_vld) - 1)];
        end
        send_item(op, sz, tid, 1'b0, none);
      end
    end

    req_ch.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0) $display("variable_partition_allocator_test passed");
    else $display("variable_partition_allocator_test failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/vpa_pkg.sv
rtl/vpa_ifs.sv
rtl/variable_partition_allocator.sv
tb/variable_partition_allocator_test.sv
